/* rtl/core/custom_section_finder_unit_assert.svh */
// ----------------------------------------------------------------------------
// custom section finder assertion macros
// shared property wrappers clocked on clk, with and without reset disable
// ----------------------------------------------------------------------------
`ifndef CUSTOM_SECTION_FINDER_UNIT_ASSERT_SVH
`define CUSTOM_SECTION_FINDER_UNIT_ASSERT_SVH

// property checked only while out of reset
`define CSF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// property checked at every edge, reset included
`define CSF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/csf_pkg.sv */
// ----------------------------------------------------------------------------
// csf_pkg
// types, constants and helpers for the custom section finder
// ----------------------------------------------------------------------------
package csf_pkg;

  // bytes of module header skipped before the first section
  localparam int unsigned HEADER_BYTES = 8;
  // longest name the configured name register can hold
  localparam int unsigned MAX_NAME_BYTES = 8;
  // leb128 numbers end after this many bytes at most
  localparam int unsigned LEB_MAX_BYTES = 5;
  localparam int unsigned LEB_DATA_BITS = 7;

  // configuration register indexes
  localparam logic [1:0] CFG_TARGET_ID          = 2'd0;
  localparam logic [1:0] CFG_TARGET_NAME        = 2'd1;
  localparam logic [1:0] CFG_TARGET_NAME_LENGTH = 2'd2;

  // configuration reset values ("portid", first byte lowest)
  localparam logic [7:0]  TARGET_ID_RESET          = 8'h00;
  localparam logic [63:0] TARGET_NAME_RESET        = 64'h0000_6469_7472_6f70;
  localparam logic [3:0]  TARGET_NAME_LENGTH_RESET = 4'd6;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_ID,
    PH_LEN_TARGET,
    PH_LEN_OTHER,
    PH_NAMELEN,
    PH_NAME,
    PH_SKIP,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic        found;
    logic [31:0] section_offset;
    logic [31:0] total_bytes;
    logic [31:0] payload_bytes;
  } result_t;

  // merge one leb128 byte into the accumulator at group position cnt
  function automatic logic [31:0] leb_merge(input logic [31:0] acc,
                                            input logic [7:0]  b,
                                            input logic [2:0]  cnt);
    logic [31:0] data;
    data = {25'd0, b[LEB_DATA_BITS-1:0]};
    case (cnt)
      3'd0:    leb_merge = acc | data;
      3'd1:    leb_merge = acc | (data << 7);
      3'd2:    leb_merge = acc | (data << 14);
      3'd3:    leb_merge = acc | (data << 21);
      default: leb_merge = acc | (data << 28);
    endcase
  endfunction

endpackage

/* rtl/core/custom_section_finder_unit.sv */
// ----------------------------------------------------------------------------
// custom_section_finder_unit
// scans a module image byte by byte for a named custom section
// ----------------------------------------------------------------------------
// Usage:
//   item channel (item_valid / item_stall / item) carries one image byte and
//   a last-byte flag. After a fixed header the sections are walked; a section
//   whose id equals target_id has its leb128 name length and name compared
//   with target_name / target_name_length.
//   result channel (result_valid / result_stall / result) gives at most one
//   item per image: found with offset and sizes at the first match, or a
//   not-found item (all fields zero) on the last byte if nothing matched.
//   Throughput: one byte per cycle while item_stall is low; the parse state
//   updates in the cycle the byte is taken. Results are registered in an
//   output register, or in one skid register while that is full and stalled.
//   item_stall is high while the skid register holds a result, which it
//   does only after the receiver stalled a full output register, so a
//   result-free byte stream keeps flowing while a result waits.
//   Reset clears the parse state, empties the output side and loads the
//   configuration reset values. The last byte returns the parser to its
//   reset state; configuration is kept. Registers are written via cfg_write.
// ----------------------------------------------------------------------------
module custom_section_finder_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  csf_pkg::item_t    item,
  output logic              result_valid,
  input  logic              result_stall,
  output csf_pkg::result_t  result,
  input  logic              cfg_write,
  input  logic [1:0]        cfg_index,
  input  logic [63:0]       cfg_data
);

  // configuration registers
  logic [7:0]  target_id;
  logic [63:0] target_name;
  logic [3:0]  target_name_length;

  // parse state
  csf_pkg::phase_t phase, phase_next;
  logic [31:0] byte_position, byte_position_next;
  logic [31:0] leb_value, leb_value_next;
  logic [2:0]  leb_byte_count, leb_byte_count_next;
  logic [31:0] section_start, section_start_next;
  logic [31:0] section_length, section_length_next;
  logic [3:0]  name_length, name_length_next;
  logic [2:0]  name_field_bytes, name_field_bytes_next;
  logic [3:0]  name_index, name_index_next;
  logic [31:0] skip_remaining, skip_remaining_next;

  // output side
  logic             skid_valid;
  csf_pkg::result_t skid;
  csf_pkg::result_t result_new;
  logic             produce;
  logic             accept;
  logic             slot_free;
  logic             load_from_skid, load_new_out, load_skid;

  // combinational helpers
  csf_pkg::phase_t phase_cur;
  logic [31:0] merged;
  logic [2:0]  count_inc;
  logic        leb_done;
  logic [31:0] skip_dec;
  logic        hit;
  logic [7:0]  want;

  assign accept     = item_valid && !item_stall;
  assign item_stall = skid_valid;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      target_id          <= csf_pkg::TARGET_ID_RESET;
      target_name        <= csf_pkg::TARGET_NAME_RESET;
      target_name_length <= csf_pkg::TARGET_NAME_LENGTH_RESET;
    end else if (cfg_write) begin
      if (cfg_index == csf_pkg::CFG_TARGET_ID) begin
        target_id <= cfg_data[7:0];
      end
      if (cfg_index == csf_pkg::CFG_TARGET_NAME) begin
        target_name <= cfg_data;
      end
      if (cfg_index == csf_pkg::CFG_TARGET_NAME_LENGTH) begin
        target_name_length <= cfg_data[3:0];
      end
    end
  end

  // parse step for one byte
  always_comb begin
    phase_next            = phase;
    byte_position_next    = byte_position + 32'd1;
    leb_value_next        = leb_value;
    leb_byte_count_next   = leb_byte_count;
    section_start_next    = section_start;
    section_length_next   = section_length;
    name_length_next      = name_length;
    name_field_bytes_next = name_field_bytes;
    name_index_next       = name_index;
    skip_remaining_next   = skip_remaining;
    hit                   = 1'b0;
    merged                = '0;
    count_inc             = '0;
    leb_done              = 1'b0;
    want                  = target_name[{name_index[2:0], 3'b000} +: 8];
    skip_dec              = (skip_remaining != 32'd0) ? skip_remaining - 32'd1 : 32'd0;

    // header ends once enough bytes went by
    phase_cur = phase;
    if (phase == csf_pkg::PH_HEADER && byte_position >= 32'(csf_pkg::HEADER_BYTES)) begin
      phase_cur  = csf_pkg::PH_ID;
      phase_next = csf_pkg::PH_ID;
    end

    unique case (phase_cur)
      csf_pkg::PH_ID: begin
        section_start_next  = byte_position;
        leb_value_next      = '0;
        leb_byte_count_next = '0;
        phase_next = (item.byte_value == target_id) ? csf_pkg::PH_LEN_TARGET
                                                    : csf_pkg::PH_LEN_OTHER;
      end
      csf_pkg::PH_LEN_TARGET, csf_pkg::PH_LEN_OTHER: begin
        merged              = csf_pkg::leb_merge(leb_value, item.byte_value, leb_byte_count);
        count_inc           = leb_byte_count + 3'd1;
        leb_done            = !item.byte_value[7] || count_inc == 3'(csf_pkg::LEB_MAX_BYTES);
        leb_value_next      = merged;
        leb_byte_count_next = count_inc;
        if (leb_done) begin
          section_length_next = merged;
          skip_remaining_next = merged;
          if (phase_cur == csf_pkg::PH_LEN_OTHER) begin
            phase_next = (merged != 32'd0) ? csf_pkg::PH_SKIP : csf_pkg::PH_ID;
          end else begin
            leb_value_next        = '0;
            name_field_bytes_next = '0;
            phase_next            = csf_pkg::PH_NAMELEN;
          end
        end
      end
      csf_pkg::PH_NAMELEN: begin
        skip_remaining_next   = skip_dec;
        merged                = csf_pkg::leb_merge(leb_value, item.byte_value, name_field_bytes);
        count_inc             = name_field_bytes + 3'd1;
        leb_done              = !item.byte_value[7] || count_inc == 3'(csf_pkg::LEB_MAX_BYTES);
        leb_value_next        = merged;
        name_field_bytes_next = count_inc;
        if (leb_done) begin
          name_length_next = merged[3:0];
          name_index_next  = '0;
          if (target_name_length > 4'(csf_pkg::MAX_NAME_BYTES) ||
              merged != 32'(target_name_length)) begin
            phase_next = (skip_dec != 32'd0) ? csf_pkg::PH_SKIP : csf_pkg::PH_ID;
          end else if (merged == 32'd0) begin
            hit = 1'b1;
          end else begin
            phase_next = csf_pkg::PH_NAME;
          end
        end
      end
      csf_pkg::PH_NAME: begin
        skip_remaining_next = skip_dec;
        if (item.byte_value != want) begin
          phase_next = (skip_dec != 32'd0) ? csf_pkg::PH_SKIP : csf_pkg::PH_ID;
        end else begin
          name_index_next = name_index + 4'd1;
          if (name_index + 4'd1 == name_length) begin
            hit = 1'b1;
          end
        end
      end
      csf_pkg::PH_SKIP: begin
        skip_remaining_next = skip_dec;
        if (skip_dec == 32'd0) begin
          phase_next = csf_pkg::PH_ID;
        end
      end
      csf_pkg::PH_HEADER, csf_pkg::PH_DONE: begin
      end
      default: begin
      end
    endcase

    if (hit) begin
      phase_next = csf_pkg::PH_DONE;
    end

    // result for this byte: match, or not found on the last byte
    produce                   = hit || (item.last_byte && phase != csf_pkg::PH_DONE);
    result_new.found          = hit;
    result_new.section_offset = hit ? section_start : 32'd0;
    result_new.total_bytes    = hit ? 32'd1 + 32'(leb_byte_count) + section_length : 32'd0;
    result_new.payload_bytes  = hit ? section_length - 32'(name_field_bytes_next)
                                      - 32'(name_length_next) : 32'd0;

    // end of image returns the parser to its start
    if (item.last_byte) begin
      phase_next         = csf_pkg::PH_HEADER;
      byte_position_next = '0;
    end
  end

  // parse state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= csf_pkg::PH_HEADER;
      byte_position <= '0;
    end else if (accept) begin
      phase         <= phase_next;
      byte_position <= byte_position_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      leb_value        <= leb_value_next;
      leb_byte_count   <= leb_byte_count_next;
      section_start    <= section_start_next;
      section_length   <= section_length_next;
      name_length      <= name_length_next;
      name_field_bytes <= name_field_bytes_next;
      name_index       <= name_index_next;
      skip_remaining   <= skip_remaining_next;
    end
  end

  // output register with skid stage
  assign slot_free      = !result_valid || !result_stall;
  assign load_from_skid = slot_free && skid_valid;
  assign load_new_out   = slot_free && !skid_valid && accept && produce;
  assign load_skid      = !slot_free && accept && produce;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else begin
      if (slot_free) begin
        result_valid <= load_from_skid || load_new_out;
      end
      if (load_from_skid) begin
        skid_valid <= 1'b0;
      end else if (load_skid) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_from_skid) begin
      result <= skid;
    end else if (load_new_out) begin
      result <= result_new;
    end
    if (load_skid) begin
      skid <= result_new;
    end
  end

endmodule

/* rtl/core/csf_checker.sv */
// ----------------------------------------------------------------------------
// csf_checker
// port-level checks for the custom section finder, bound into custom_section_finder_unit
// ----------------------------------------------------------------------------
`include "custom_section_finder_unit_assert.svh"

module csf_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_stall,
  input logic              result_valid,
  input logic              result_stall,
  input csf_pkg::result_t  result
);

  logic held;
  logic zero_fields;

  // result waiting on the receiver, and an all-zero payload
  assign held        = result_valid && result_stall;
  assign zero_fields = result.section_offset == 32'd0 && result.total_bytes == 32'd0 &&
                       result.payload_bytes == 32'd0;

  // stalled result item holds
  `CSF_ASSERT(a_result_hold, held |=> result_valid && $stable(result), "stalled result changed")

  // a not-found item carries zero fields
  `CSF_ASSERT(a_not_found_zero, result_valid && !result.found |-> zero_fields, "nonzero not-found")

  // input stalls only after the receiver held a result back
  `CSF_ASSERT(a_stall_cause, $rose(item_stall) |-> $past(held), "stall without backpressure")

  // reset empties the output side
  `CSF_ASSERT_ALWAYS(a_reset_empty, rst |=> !result_valid && !item_stall, "busy after reset")

endmodule

bind custom_section_finder_unit csf_checker u_csf_checker (.*);

/* sim/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for custom_section_finder_unit: module images go in one
// byte per item, a local parser predicts every found / not-found item, and
// the result channel is checked field by field under random gaps and stalls
// ----------------------------------------------------------------------------
module tb;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_BYTES = 1100;
  localparam int BACKLOG_HOLD = 400;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             item_valid = 1'b0;
  logic             item_stall;
  csf_pkg::item_t   item = '0;
  logic             result_valid;
  logic             result_stall = 1'b0;
  csf_pkg::result_t result;
  logic             cfg_write = 1'b0;
  logic [1:0]       cfg_index = csf_pkg::CFG_TARGET_ID;
  logic [63:0]      cfg_data = '0;

  custom_section_finder_unit dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #1 clk = ~clk;

  // configured search target, mirrored on every register write
  logic [7:0]  want_id   = csf_pkg::TARGET_ID_RESET;
  logic [63:0] want_name = csf_pkg::TARGET_NAME_RESET;
  logic [3:0]  want_len  = csf_pkg::TARGET_NAME_LENGTH_RESET;

  // parser state of the predictor
  logic [31:0]     byte_pos;
  csf_pkg::phase_t parse_state;
  logic [31:0]     len_acc;
  logic [2:0]      len_groups;
  logic [31:0]     sec_start;
  logic [31:0]     sec_len;
  logic [31:0]     name_len;
  logic [2:0]      name_groups;
  logic [3:0]      name_idx;
  logic [31:0]     body_left;
  logic            reported;

  csf_pkg::result_t expected_results[$];
  logic [7:0]       image_q[$];
  logic [7:0]       body_q[$];

  bit noisy = 1'b1;
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;
  int cycle_count = 0;
  int errors = 0;
  int bytes_sent = 0;
  int images_sent = 0;
  int settings_used = 0;
  int found_seen = 0;
  int missing_seen = 0;

  // ---------------------------------------------------------------- predictor

  function automatic void clear_parse();
    byte_pos    = '0;
    parse_state = csf_pkg::PH_HEADER;
    len_acc     = '0;
    len_groups  = '0;
    sec_start   = '0;
    sec_len     = '0;
    name_len    = '0;
    name_groups = '0;
    name_idx    = '0;
    body_left   = '0;
    reported    = 1'b0;
  endfunction

  // add one leb128 group to len_acc, return the new group count
  function automatic logic [2:0] absorb_group(input logic [7:0] b, input logic [2:0] groups);
    logic [2:0] g;
    g = (groups > 3'd4) ? 3'd4 : groups;
    len_acc = len_acc | ({25'd0, b[6:0]} << (7 * g));
    return g + 3'd1;
  endfunction

  function automatic void leave_body();
    if (body_left != 0) parse_state = csf_pkg::PH_SKIP;
    else parse_state = csf_pkg::PH_ID;
  endfunction

  function automatic void eat_body_byte();
    if (body_left != 0) body_left = body_left - 1;
  endfunction

  task automatic predict_byte(input csf_pkg::item_t it);
    logic [7:0]       b;
    logic             hit;
    csf_pkg::result_t r;
    b = it.byte_value;
    hit = 1'b0;
    if (parse_state == csf_pkg::PH_HEADER && byte_pos >= csf_pkg::HEADER_BYTES)
      parse_state = csf_pkg::PH_ID;
    case (parse_state)
      csf_pkg::PH_ID: begin
        sec_start  = byte_pos;
        len_acc    = '0;
        len_groups = '0;
        if (b == want_id) parse_state = csf_pkg::PH_LEN_TARGET;
        else parse_state = csf_pkg::PH_LEN_OTHER;
      end
      csf_pkg::PH_LEN_TARGET, csf_pkg::PH_LEN_OTHER: begin
        len_groups = absorb_group(b, len_groups);
        if (!b[7] || len_groups == csf_pkg::LEB_MAX_BYTES) begin
          sec_len   = len_acc;
          body_left = len_acc;
          if (parse_state == csf_pkg::PH_LEN_OTHER) begin
            leave_body();
          end else begin
            len_acc     = '0;
            name_groups = '0;
            parse_state = csf_pkg::PH_NAMELEN;
          end
        end
      end
      csf_pkg::PH_NAMELEN: begin
        eat_body_byte();
        name_groups = absorb_group(b, name_groups);
        if (!b[7] || name_groups == csf_pkg::LEB_MAX_BYTES) begin
          name_len = len_acc;
          name_idx = '0;
          if (want_len > csf_pkg::MAX_NAME_BYTES || name_len != {28'd0, want_len}) leave_body();
          else if (name_len == 0) hit = 1'b1;
          else parse_state = csf_pkg::PH_NAME;
        end
      end
      csf_pkg::PH_NAME: begin
        eat_body_byte();
        if (b != want_name[name_idx[2:0] * 8 +: 8]) begin
          leave_body();
        end else begin
          name_idx = name_idx + 4'd1;
          if ({28'd0, name_idx} == name_len) hit = 1'b1;
        end
      end
      csf_pkg::PH_SKIP: begin
        eat_body_byte();
        if (body_left == 0) parse_state = csf_pkg::PH_ID;
      end
      default: ;
    endcase

    if (hit) begin
      reported = 1'b1;
      parse_state = csf_pkg::PH_DONE;
      r.found          = 1'b1;
      r.section_offset = sec_start;
      r.total_bytes    = 32'd1 + {29'd0, len_groups} + sec_len;
      r.payload_bytes  = sec_len - {29'd0, name_groups} - name_len;
      expected_results.push_back(r);
    end
    byte_pos = byte_pos + 1;

    // end of image: not-found item unless a match went out, then restart
    if (it.last_byte) begin
      if (!reported) expected_results.push_back('0);
      clear_parse();
    end
  endtask

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what, input logic [31:0] got_v,
                                 input logic [31:0] exp_v);
    $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got_v, exp_v);
    errors++;
  endtask

  task automatic check_result(input csf_pkg::result_t got);
    csf_pkg::result_t exp_r;
    if (expected_results.size() == 0) begin
      report_mismatch("result with none pending", {31'd0, got.found}, 32'd0);
    end else begin
      exp_r = expected_results.pop_front();
      if (got.found != exp_r.found)
        report_mismatch("found", {31'd0, got.found}, {31'd0, exp_r.found});
      if (got.section_offset != exp_r.section_offset)
        report_mismatch("section_offset", got.section_offset, exp_r.section_offset);
      if (got.total_bytes != exp_r.total_bytes)
        report_mismatch("total_bytes", got.total_bytes, exp_r.total_bytes);
      if (got.payload_bytes != exp_r.payload_bytes)
        report_mismatch("payload_bytes", got.payload_bytes, exp_r.payload_bytes);
      if (exp_r.found) found_seen++;
      else missing_seen++;
    end
  endtask

  // predict on every accepted byte, check every accepted result
  always @(posedge clk) begin
    if (rst) begin
      clear_parse();
    end else begin
      if (item_valid && !item_stall) predict_byte(item);
      if (result_valid && !result_stall) check_result(result);
    end
  end

  // result side: random stalls, or a long hold when one is requested
  always @(posedge clk) begin
    if (hold_left > 0) begin
      result_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_served != hold_requests) begin
      result_stall <= 1'b1;
      hold_left <= BACKLOG_HOLD;
      holds_served <= holds_served + 1;
    end else begin
      result_stall <= noisy && ($urandom_range(99) < 32);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------- driving

  task automatic send_byte(input logic [7:0] b, input logic last);
    while (noisy && $urandom_range(99) < 32) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= '{byte_value: b, last_byte: last};
    @(posedge clk);
    while (item_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_image();
    foreach (image_q[i]) send_byte(image_q[i], i == image_q.size() - 1);
    images_sent++;
  endtask

  // drain every pending result, then give the block a few quiet cycles
  task automatic wait_idle();
    item_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // write all three registers back to back; spare data bits carry junk
  task automatic set_config(input logic [7:0] id, input logic [63:0] name,
                            input logic [3:0] len);
    logic [63:0] junk;
    wait_idle();
    junk = {$urandom, $urandom};
    cfg_write <= 1'b1;
    cfg_index <= csf_pkg::CFG_TARGET_ID;
    cfg_data  <= {junk[63:8], id};
    @(posedge clk);
    cfg_index <= csf_pkg::CFG_TARGET_NAME;
    cfg_data  <= name;
    @(posedge clk);
    cfg_index <= csf_pkg::CFG_TARGET_NAME_LENGTH;
    cfg_data  <= {junk[59:0], len};
    @(posedge clk);
    cfg_write <= 1'b0;
    want_id   = id;
    want_name = name;
    want_len  = len;
    settings_used++;
  endtask

  // ---------------------------------------------------------------- image building

  // leb128 with optional padding groups; a five-group form gets junk in the
  // dropped bits and sometimes a continuation flag on its last group
  function automatic int leb_encode(input logic [31:0] v, input int pad,
                                    output logic [39:0] enc);
    int groups;
    int total;
    groups = 1;
    while (groups < 5 && (v >> (7 * groups)) != 0) groups++;
    total = (groups + pad > 5) ? 5 : groups + pad;
    enc = '0;
    for (int i = 0; i < total; i++) begin
      enc[8 * i +: 8] = {i < total - 1, 7'(v >> (7 * i))};
    end
    if (total == 5) enc[39:36] = enc[39:36] | 4'($urandom_range(15));
    return total;
  endfunction

  task automatic add_leb(input logic [31:0] v, input bit to_body);
    logic [39:0] enc;
    int n;
    n = leb_encode(v, ($urandom_range(7) == 0) ? int'($urandom_range(1, 4)) : 0, enc);
    for (int i = 0; i < n; i++) begin
      if (to_body) body_q.push_back(enc[8 * i +: 8]);
      else image_q.push_back(enc[8 * i +: 8]);
    end
  endtask

  // mostly well-formed images: header, a few sections, some trailing noise
  task automatic build_random_image();
    int sections;
    int kind;
    int extra;
    int nl;
    int flip;
    logic [7:0]  id;
    logic [7:0]  nb;
    logic [31:0] declared;
    image_q.delete();
    if ($urandom_range(11) == 0) begin
      // bare noise, often ending inside the header
      extra = $urandom_range(1, 24);
      repeat (extra) image_q.push_back(8'($urandom));
    end else begin
      repeat (csf_pkg::HEADER_BYTES) image_q.push_back(8'($urandom));
      sections = $urandom_range(0, 4);
      repeat (sections) begin
        kind = $urandom_range(9);
        body_q.delete();
        if (kind < 3) begin
          // some other section, possibly empty
          id = 8'($urandom);
          if (id == want_id) id = ~id;
          extra = $urandom_range(0, 5);
          repeat (extra) body_q.push_back(8'($urandom));
          declared = 32'(body_q.size());
        end else begin
          // target section: wrong name length, one bad name byte, short header
          // length, or a clean match
          id = want_id;
          nl = want_len;
          if (kind == 3) nl = (nl + $urandom_range(1, 3)) % 12;
          add_leb(32'(nl), 1'b1);
          flip = (kind == 4 && nl > 0) ? int'($urandom_range(0, nl - 1)) : -1;
          for (int i = 0; i < nl; i++) begin
            nb = want_name[8 * (i % 8) +: 8];
            if (i == flip) nb = nb ^ (8'd1 << $urandom_range(7));
            body_q.push_back(nb);
          end
          extra = $urandom_range(0, 4);
          repeat (extra) body_q.push_back(8'($urandom));
          declared = 32'(body_q.size());
          if (kind == 5) declared = $urandom_range(0, body_q.size());
          if ($urandom_range(39) == 0) declared = 32'hffff_ff00 | 32'($urandom_range(255));
        end
        image_q.push_back(id);
        add_leb(declared, 1'b0);
        foreach (body_q[i]) image_q.push_back(body_q[i]);
      end
      extra = $urandom_range(0, 2);
      repeat (extra) image_q.push_back(8'($urandom));
    end
  endtask

  // ---------------------------------------------------------------- tests

  // reset register values: "portid" completed by the final byte, then a
  // one-byte image that ends in the header
  task automatic test_default_config();
    image_q = '{8'h00, 8'h61, 8'h73, 8'h6d, 8'h01, 8'h00, 8'h00, 8'h00,
                8'h00, 8'h07, 8'h06, 8'h70, 8'h6f, 8'h72, 8'h74, 8'h69, 8'h64};
    send_image();
    image_q = '{8'hff};
    send_image();
  endtask

  task automatic test_config_extremes();
    // empty name matched at the end of its length field; five-group lengths,
    // zero-length other section, wrapped sizes, bytes after the match
    set_config(8'hff, '1, 4'd0);
    image_q = '{8'h00, 8'hff, 8'h00, 8'hff, 8'h00, 8'hff, 8'h00, 8'hff,
                8'h05, 8'h80, 8'h80, 8'h80, 8'h80, 8'hf0,
                8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'h0f, 8'h00, 8'h55, 8'haa};
    send_image();
    // longest name, all zero bytes
    set_config(8'h00, '0, 4'd8);
    image_q = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                8'h00, 8'h09, 8'h08, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                8'h00, 8'h00, 8'h00, 8'hff};
    send_image();
  endtask

  // hold the result side off while short not-found images keep coming
  task automatic test_output_backlog();
    wait_idle();
    noisy = 1'b0;
    hold_requests++;
    repeat (30) begin
      image_q.delete();
      repeat (csf_pkg::HEADER_BYTES + 1) image_q.push_back(8'($urandom));
      send_image();
    end
    wait_idle();
    noisy = 1'b1;
  endtask

  task automatic test_random_images();
    int phase_no;
    int start;
    int count;
    logic [3:0] len;
    phase_no = 0;
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_BYTES) begin
      len = ($urandom_range(5) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
      case (phase_no)
        0:       set_config(8'h00, '0, 4'd1);
        1:       set_config(8'hff, '1, 4'd8);
        2:       set_config(8'($urandom), {$urandom, $urandom}, 4'd15);
        default: set_config(8'($urandom), {$urandom, $urandom}, len);
      endcase
      // every fifth setting runs with no idling on either side
      noisy = (phase_no % 5 != 3);
      count = $urandom_range(4, 8);
      repeat (count) begin
        build_random_image();
        send_image();
      end
      phase_no++;
    end
    noisy = 1'b1;
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_default_config();
    test_config_extremes();
    test_output_backlog();
    test_random_images();
    wait_idle();
    $display("covered %0d images in %0d bytes over %0d register settings",
             images_sent, bytes_sent, settings_used);
    $display("checked %0d found and %0d not-found results, %0d mismatches",
             found_seen, missing_seen, errors);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
